// File: rtl/phd_pkg.sv
// shared types, constants and state codes of the proximity haptic driver
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package phd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FLEX_THR   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAV_THR    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_THR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PWM    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PWM    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_START_MODE = 3'd7;

    // reset values of the registers
    localparam logic [11:0] FLEX_THR_RST   = 12'd500;
    localparam logic [9:0]  NAV_THR_RST    = 10'd80;
    localparam logic [9:0]  CLOSE_THR_RST  = 10'd4;
    localparam logic [8:0]  ALPHA_RST      = 9'd90;
    localparam logic [15:0] DEBOUNCE_RST   = 16'd200;
    localparam logic [7:0]  MIN_PWM_RST    = 8'd100;
    localparam logic [7:0]  MAX_PWM_RST    = 8'd255;
    localparam logic [1:0]  START_MODE_RST = 2'd1;

    // mode codes
    localparam logic [1:0] MODE_NAV   = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    localparam logic [8:0] ALPHA_ONE = 9'd256;

    // mm to cm: x / 10 == (x * 52429) >> 19 for every 13 bit x
    localparam logic [16:0] DIV10_RECIP = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    // duty quotient dividend width, one bit per divider step
    localparam int          DIV_W     = 18;
    localparam int          DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

    typedef struct packed {
        logic        button_level;
        logic        sample_present;
        logic [11:0] flex_value;
        logic [12:0] range_mm;
        logic        out_of_range;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  motor_pwm;
        logic [1:0]  current_mode;
        logic        mode_changed;
        logic [17:0] smoothed_distance;
        logic        distance_valid;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_FILT_A,
        ST_FILT_B,
        ST_DUTY_MUL,
        ST_DIVIDE,
        ST_DUTY_FIN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic convert;
        logic filt_a;
        logic filt_b;
        logic duty_mul;
        logic div_step;
        logic duty_fin;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sample_live;
        logic filt_done_a;
        logic duty_skip;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/phd_ctrl.sv
// sequencer of the proximity haptic driver: steps one word through the datapath
// depends on phd_pkg
`default_nettype none

module phd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire phd_pkg::status_t status,
    output phd_pkg::cmd_t        cmd,
    output logic                 in_ready
);

    phd_pkg::state_t state_reg;
    phd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            phd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.sample_live ? phd_pkg::ST_CONVERT : phd_pkg::ST_EMIT;
                end
            end
            phd_pkg::ST_CONVERT:
            begin
                state_next = phd_pkg::ST_FILT_A;
            end
            phd_pkg::ST_FILT_A:
            begin
                state_next = status.filt_done_a ? phd_pkg::ST_DUTY_MUL : phd_pkg::ST_FILT_B;
            end
            phd_pkg::ST_FILT_B:
            begin
                state_next = phd_pkg::ST_DUTY_MUL;
            end
            phd_pkg::ST_DUTY_MUL:
            begin
                state_next = status.duty_skip ? phd_pkg::ST_EMIT : phd_pkg::ST_DIVIDE;
            end
            phd_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = phd_pkg::ST_DUTY_FIN;
                end
            end
            phd_pkg::ST_DUTY_FIN:
            begin
                state_next = phd_pkg::ST_EMIT;
            end
            phd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = phd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = phd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            phd_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            phd_pkg::ST_CONVERT:  cmd.convert  = 1'b1;
            phd_pkg::ST_FILT_A:   cmd.filt_a   = 1'b1;
            phd_pkg::ST_FILT_B:   cmd.filt_b   = 1'b1;
            phd_pkg::ST_DUTY_MUL: cmd.duty_mul = 1'b1;
            phd_pkg::ST_DIVIDE:   cmd.div_step = 1'b1;
            phd_pkg::ST_DUTY_FIN: cmd.duty_fin = 1'b1;
            phd_pkg::ST_EMIT:     cmd.emit     = status.out_free;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/phd_dp.sv
// datapath of the proximity haptic driver: registers, debounce, filter,
// serial duty divider and output register; depends on phd_pkg
`default_nettype none

module phd_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [phd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [phd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire phd_pkg::in_word_t                 in_data,
    input  wire phd_pkg::cmd_t                     cmd,
    input  wire logic                              out_ready,
    output phd_pkg::status_t                       status,
    output logic                                   out_valid,
    output phd_pkg::out_word_t                     out_data
);

    // configuration
    logic [11:0] flex_thr_reg;
    logic [9:0]  nav_thr_reg;
    logic [9:0]  close_thr_reg;
    logic [8:0]  alpha_reg;
    logic [15:0] debounce_reg;
    logic [7:0]  min_pwm_reg;
    logic [7:0]  max_pwm_reg;

    // state
    logic        mode_close_reg,   mode_close_next;
    logic        last_button_reg,  last_button_next;
    logic        deb_button_reg,   deb_button_next;
    logic [15:0] stable_cnt_reg,   stable_cnt_next;
    logic [17:0] filter_reg,       filter_next;
    logic        filter_ok_reg,    filter_ok_next;
    logic [7:0]  pwm_reg,          pwm_next;
    logic        changed_reg,      changed_next;
    logic        out_valid_reg,    out_valid_next;
    logic [phd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // payload
    logic [12:0]              range_reg;
    logic                     oor_reg;
    logic [9:0]               raw_reg;
    logic [26:0]              prod_a_reg;
    logic [phd_pkg::DIV_W-1:0] quo_reg,  quo_next;
    logic [9:0]               rem_reg,  rem_next;
    logic                     neg_reg,  neg_next;
    phd_pkg::out_word_t       out_reg;

    logic [15:0] stable_calc;
    logic [8:0]  alpha_sat;
    logic [8:0]  alpha_inv;
    logic [9:0]  thr;
    logic [29:0] div10_prod;
    logic [27:0] filt_sum;
    logic [9:0]  dist_cm;
    logic [9:0]  diff;
    logic signed [8:0]  span;
    logic signed [19:0] duty_prod;
    logic [19:0] duty_mag;
    logic        eligible;
    logic [10:0] trial;
    logic signed [10:0] quo_s;
    logic signed [10:0] duty_s;

    assign alpha_sat = (alpha_reg > phd_pkg::ALPHA_ONE) ? phd_pkg::ALPHA_ONE : alpha_reg;
    assign alpha_inv = phd_pkg::ALPHA_ONE - alpha_sat;
    assign thr       = mode_close_reg ? close_thr_reg : nav_thr_reg;

    assign div10_prod = 30'(range_reg) * 30'(phd_pkg::DIV10_RECIP);
    assign filt_sum   = 28'(prod_a_reg) + 28'(alpha_inv) * 28'(filter_reg) + 28'd128;

    assign dist_cm   = filter_reg[17:8];
    assign diff      = thr - dist_cm;
    assign span      = $signed({1'b0, max_pwm_reg}) - $signed({1'b0, min_pwm_reg});
    assign duty_prod = $signed({9'd0, diff}) * 20'(span);
    assign duty_mag  = duty_prod[19] ? 20'(-duty_prod) : 20'(duty_prod);
    assign eligible  = filter_ok_reg && (filter_reg != '0) && (thr != '0)
                     && (filter_reg < {thr, 8'd0});

    assign trial  = {rem_reg, quo_reg[phd_pkg::DIV_W-1]};
    assign quo_s  = neg_reg ? -$signed({1'b0, quo_reg[9:0]}) : $signed({1'b0, quo_reg[9:0]});
    assign duty_s = $signed({3'd0, min_pwm_reg}) + quo_s;

    assign stable_calc = (in_data.button_level != last_button_reg) ? 16'd0 :
                         (stable_cnt_reg != 16'hFFFF) ? stable_cnt_reg + 16'd1 : stable_cnt_reg;

    always_comb
    begin
        mode_close_next  = mode_close_reg;
        last_button_next = last_button_reg;
        deb_button_next  = deb_button_reg;
        stable_cnt_next  = stable_cnt_reg;
        filter_next      = filter_reg;
        filter_ok_next   = filter_ok_reg;
        pwm_next         = pwm_reg;
        changed_next     = changed_reg;
        cnt_next         = cnt_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        neg_next         = neg_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cfg_we && (cfg_index == phd_pkg::REG_START_MODE))
        begin
            mode_close_next = (cfg_data[1:0] == phd_pkg::MODE_CLOSE);
        end

        if (cmd.accept)
        begin
            stable_cnt_next  = stable_calc;
            last_button_next = in_data.button_level;
            changed_next     = 1'b0;
            if ((stable_calc >= debounce_reg) && (in_data.button_level != deb_button_reg))
            begin
                deb_button_next = in_data.button_level;
                if (!in_data.button_level)
                begin
                    mode_close_next = !mode_close_reg;
                    changed_next    = 1'b1;
                end
            end
            // sensing switched off by the flex reading
            if (in_data.sample_present && (in_data.flex_value <= flex_thr_reg))
            begin
                filter_next    = '0;
                filter_ok_next = 1'b0;
                pwm_next       = '0;
            end
        end

        if (cmd.filt_a)
        begin
            if (oor_reg || (raw_reg == '0))
            begin
                filter_next    = '0;
                filter_ok_next = 1'b0;
            end
            else if (!filter_ok_reg)
            begin
                filter_next    = {raw_reg, 8'd0};
                filter_ok_next = 1'b1;
            end
        end

        if (cmd.filt_b)
        begin
            filter_next = filt_sum[25:8];
        end

        if (cmd.duty_mul)
        begin
            quo_next = duty_mag[phd_pkg::DIV_W-1:0];
            rem_next = '0;
            neg_next = duty_prod[19];
            cnt_next = phd_pkg::DIV_STEPS;
            if (!eligible)
            begin
                pwm_next = '0;
            end
        end

        // restoring divide by the threshold, one quotient bit a cycle
        if (cmd.div_step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, thr})
            begin
                rem_next = 10'(trial - {1'b0, thr});
                quo_next = {quo_reg[phd_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[9:0];
                quo_next = {quo_reg[phd_pkg::DIV_W-2:0], 1'b0};
            end
        end

        if (cmd.duty_fin)
        begin
            if (duty_s < 0)
            begin
                pwm_next = '0;
            end
            else if (duty_s > $signed({3'd0, max_pwm_reg}))
            begin
                pwm_next = max_pwm_reg;
            end
            else
            begin
                pwm_next = duty_s[7:0];
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flex_thr_reg    <= phd_pkg::FLEX_THR_RST;
            nav_thr_reg     <= phd_pkg::NAV_THR_RST;
            close_thr_reg   <= phd_pkg::CLOSE_THR_RST;
            alpha_reg       <= phd_pkg::ALPHA_RST;
            debounce_reg    <= phd_pkg::DEBOUNCE_RST;
            min_pwm_reg     <= phd_pkg::MIN_PWM_RST;
            max_pwm_reg     <= phd_pkg::MAX_PWM_RST;
            mode_close_reg  <= (phd_pkg::START_MODE_RST == phd_pkg::MODE_CLOSE);
            last_button_reg <= 1'b1;
            deb_button_reg  <= 1'b1;
            stable_cnt_reg  <= '0;
            filter_reg      <= '0;
            filter_ok_reg   <= 1'b0;
            pwm_reg         <= '0;
            changed_reg     <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    phd_pkg::REG_FLEX_THR:   flex_thr_reg  <= cfg_data[11:0];
                    phd_pkg::REG_NAV_THR:    nav_thr_reg   <= cfg_data[9:0];
                    phd_pkg::REG_CLOSE_THR:  close_thr_reg <= cfg_data[9:0];
                    phd_pkg::REG_ALPHA:      alpha_reg     <= cfg_data[8:0];
                    phd_pkg::REG_DEBOUNCE:   debounce_reg  <= cfg_data;
                    phd_pkg::REG_MIN_PWM:    min_pwm_reg   <= cfg_data[7:0];
                    phd_pkg::REG_MAX_PWM:    max_pwm_reg   <= cfg_data[7:0];
                    phd_pkg::REG_START_MODE: ;
                    default: ;
                endcase
            end
            mode_close_reg  <= mode_close_next;
            last_button_reg <= last_button_next;
            deb_button_reg  <= deb_button_next;
            stable_cnt_reg  <= stable_cnt_next;
            filter_reg      <= filter_next;
            filter_ok_reg   <= filter_ok_next;
            pwm_reg         <= pwm_next;
            changed_reg     <= changed_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            range_reg <= in_data.range_mm;
            oor_reg   <= in_data.out_of_range;
        end
        if (cmd.convert)
        begin
            raw_reg <= div10_prod[phd_pkg::DIV10_SHIFT+9:phd_pkg::DIV10_SHIFT];
        end
        if (cmd.filt_a)
        begin
            prod_a_reg <= 27'(alpha_sat) * 27'({raw_reg, 8'd0});
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        if (cmd.emit)
        begin
            out_reg.motor_pwm         <= pwm_reg;
            out_reg.current_mode      <= mode_close_reg ? phd_pkg::MODE_CLOSE
                                                        : phd_pkg::MODE_NAV;
            out_reg.mode_changed      <= changed_reg;
            out_reg.smoothed_distance <= filter_ok_reg ? filter_reg : 18'd0;
            out_reg.distance_valid    <= filter_ok_reg;
        end
    end

    assign status.sample_live = in_data.sample_present && (in_data.flex_value > flex_thr_reg);
    assign status.filt_done_a = oor_reg || (raw_reg == '0) || !filter_ok_reg;
    assign status.duty_skip   = !eligible;
    assign status.div_last    = (cnt_reg == phd_pkg::DIV_CNT_W'(1));
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: rtl/proximity_haptic_driver.sv
// top level of the proximity haptic driver: sequencer plus datapath
// depends on phd_pkg, phd_ctrl and phd_dp
`default_nettype none

// One input word per sensor tick: the button level is debounced and a
// debounced press toggles navigation and close range mode; a sample with a
// live flex reading is converted to cm, smoothed in Q10.8 and turned into a
// motor duty below the active threshold. Words are taken one at a time. A
// word without a live sample (none present, or flex at or below its
// threshold) goes straight to its result word; a live sample that gives no
// duty passes conversion, filter and duty multiply; one below the threshold
// also passes the 18 step serial divider that divides the duty ramp by the
// threshold. Smoothing into an already valid filter adds a second filter
// step to a live sample. The result waits in an output register, so the
// next word is accepted while the last one is unread. Configuration writes
// take effect at once; the user must make them while idle (not enforced).
module proximity_haptic_driver (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire phd_pkg::in_word_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output phd_pkg::out_word_t                     out_data,
    input  wire logic                              cfg_we,
    input  wire logic [phd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [phd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    phd_pkg::cmd_t    cmd;
    phd_pkg::status_t status;

    phd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    phd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: rtl/phd_checker.sv
// port level checks of the proximity haptic driver, bound to the top level
// depends on phd_pkg
`default_nettype none

module phd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire phd_pkg::in_word_t                 in_data,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire phd_pkg::out_word_t                out_data
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // an offered input word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input word changed while waiting");

    // one word in flight: busy right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.current_mode == phd_pkg::MODE_NAV
                   || out_data.current_mode == phd_pkg::MODE_CLOSE)
        else $error("bad mode code on result");

    // the filter never holds zero while valid, and reads zero when invalid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.distance_valid == (out_data.smoothed_distance != 18'd0)))
        else $error("distance value disagrees with its valid flag");

endmodule

bind proximity_haptic_driver phd_checker u_phd_checker (.*);

`default_nettype wire

// File: tb/proximity_haptic_driver_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the proximity haptic driver: a directed table, then random phases
// depends on phd_pkg and the block's rtl; stands alone otherwise

module proximity_haptic_driver_tb;
    import phd_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int RUN_LIMIT       = 700000;
    localparam int SETTLE_WAIT     = 4;
    localparam int TAIL_WAIT       = 32;
    localparam int MAX_GAP         = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 240;
    localparam int PRESSURE_PHASE  = 4;
    localparam int REG_COUNT       = 8;
    localparam int REG_BITS [REG_COUNT] = '{12, 10, 10, 9, 16, 8, 8, 2};

    // start_mode encodings outside the two modes, both fall back to navigation
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_BOTH = MODE_NAV | MODE_CLOSE;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        in_word_t               word;
        bit                     typed;
        out_word_t              typed_result;
    } step_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_word_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies
    logic [11:0] flex_limit;
    logic [9:0]  nav_cm;
    logic [9:0]  close_cm;
    logic [8:0]  weight;
    logic [15:0] settle_ticks;
    logic [7:0]  duty_floor;
    logic [7:0]  duty_ceil;

    // predicted block state
    logic        in_close;
    logic        prev_level;
    logic        held_level;
    logic [15:0] steady_run;
    logic [17:0] avg_q8;
    logic        avg_ok;
    logic [7:0]  duty_held;

    out_word_t awaited_outputs [$];
    step_t     script [$];
    out_word_t want_word;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        tx_idle_pct    = 0;
    int        rx_stall_pct   = 0;
    bit        hold_off_req   = 1'b0;
    logic      level_now      = 1'b1;
    int        level_left     = 0;

    proximity_haptic_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $error("run limit of %0d cycles reached", RUN_LIMIT);
            $display("proximity_haptic_driver_tb NOT OK");
            $finish;
        end
    end

    // linear ramp from duty_floor at the threshold to duty_ceil at zero distance
    function automatic logic [7:0] ramp_duty(logic [9:0] limit_cm);
        int d;
        int q;
        int duty;
        if (!avg_ok || avg_q8 == 0 || limit_cm == 0 || avg_q8 >= {limit_cm, 8'd0})
            return 8'd0;
        d = int'(avg_q8 >> 8);
        q = ((int'(limit_cm) - d) * (int'(duty_ceil) - int'(duty_floor))) / int'(limit_cm);
        duty = int'(duty_floor) + q;
        if (duty < 0)
            duty = 0;
        if (duty > int'(duty_ceil))
            duty = int'(duty_ceil);
        return duty[7:0];
    endfunction

    // advances the predicted state by one tick and returns the result word it gives
    function automatic out_word_t next_haptic_word(in_word_t w);
        out_word_t   r;
        logic [9:0]  cm;
        int unsigned a;
        int unsigned mix;
        r = '0;
        if (w.button_level != prev_level)
            steady_run = '0;
        else if (steady_run != 16'hFFFF)
            steady_run++;
        if (steady_run >= settle_ticks && w.button_level != held_level)
        begin
            held_level = w.button_level;
            if (!w.button_level)
            begin
                in_close = !in_close;
                r.mode_changed = 1'b1;
            end
        end
        prev_level = w.button_level;
        if (w.sample_present)
        begin
            if (w.flex_value <= flex_limit)
            begin
                avg_q8 = '0;
                avg_ok = 1'b0;
                duty_held = '0;
            end
            else
            begin
                cm = w.range_mm / 10;
                if (w.out_of_range || cm == 0)
                begin
                    avg_q8 = '0;
                    avg_ok = 1'b0;
                end
                else if (!avg_ok)
                begin
                    avg_q8 = {cm, 8'd0};
                    avg_ok = 1'b1;
                end
                else
                begin
                    a = (weight > ALPHA_ONE) ? ALPHA_ONE : weight;
                    mix = (a * {cm, 8'd0} + (ALPHA_ONE - a) * avg_q8 + 128) >> 8;
                    avg_q8 = mix[17:0];
                end
                duty_held = ramp_duty(in_close ? close_cm : nav_cm);
            end
        end
        r.motor_pwm = duty_held;
        r.current_mode = in_close ? MODE_CLOSE : MODE_NAV;
        r.smoothed_distance = avg_ok ? avg_q8 : '0;
        r.distance_valid = avg_ok;
        return r;
    endfunction

    function automatic in_word_t tick_of(logic btn, logic pres, logic [11:0] flex,
                                         logic [12:0] rng, logic oor);
        in_word_t w;
        w.button_level = btn;
        w.sample_present = pres;
        w.flex_value = flex;
        w.range_mm = rng;
        w.out_of_range = oor;
        return w;
    endfunction

    function automatic out_word_t result_of(logic [7:0] pwm, logic [1:0] mode, logic changed,
                                            logic [17:0] dist_q8, logic ok);
        out_word_t r;
        r.motor_pwm = pwm;
        r.current_mode = mode;
        r.mode_changed = changed;
        r.smoothed_distance = dist_q8;
        r.distance_valid = ok;
        return r;
    endfunction

    function automatic void add_tick(in_word_t w);
        step_t s;
        s.is_write = 1'b0;
        s.reg_index = '0;
        s.reg_value = '0;
        s.word = w;
        s.typed = 1'b0;
        s.typed_result = '0;
        script.push_back(s);
    endfunction

    function automatic void add_checked_tick(in_word_t w, out_word_t r);
        step_t s;
        s.is_write = 1'b0;
        s.reg_index = '0;
        s.reg_value = '0;
        s.word = w;
        s.typed = 1'b1;
        s.typed_result = r;
        script.push_back(s);
    endfunction

    function automatic void add_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        step_t s;
        s.is_write = 1'b1;
        s.reg_index = idx;
        s.reg_value = val;
        s.word = '0;
        s.typed = 1'b0;
        s.typed_result = '0;
        script.push_back(s);
    endfunction

    // button held in runs, mostly long enough to pass a debounce of up to 300 ticks, sometimes a bounce
    function automatic in_word_t random_tick();
        in_word_t w;
        int       pick;
        int       hi;
        if (level_left == 0)
        begin
            level_now = !level_now;
            if ($urandom_range(99) < 30 || settle_ticks > 300)
                level_left = $urandom_range(1, 3);
            else
                level_left = int'(settle_ticks) + $urandom_range(1, 8);
        end
        level_left--;
        w.button_level = level_now;
        w.sample_present = ($urandom_range(99) < 75);
        pick = $urandom_range(99);
        if (pick < 15)
            w.flex_value = 12'($urandom_range(0, flex_limit));
        else if (pick < 30 || flex_limit == 12'hFFF)
            w.flex_value = 12'($urandom_range(0, 4095));
        else
            w.flex_value = 12'($urandom_range(int'(flex_limit) + 1, 4095));
        pick = $urandom_range(99);
        hi = 15 * int'(in_close ? close_cm : nav_cm) + 20;
        if (hi > 8191)
            hi = 8191;
        if (pick < 20)
            w.range_mm = 13'($urandom_range(0, 8191));
        else if (pick < 25)
            w.range_mm = 13'($urandom_range(0, 9));
        else
            w.range_mm = 13'($urandom_range(10, hi));
        w.out_of_range = ($urandom_range(99) < 8);
        return w;
    endfunction

    // called just after a falling edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            REG_FLEX_THR:   flex_limit = val[11:0];
            REG_NAV_THR:    nav_cm = val[9:0];
            REG_CLOSE_THR:  close_cm = val[9:0];
            REG_ALPHA:      weight = val[8:0];
            REG_DEBOUNCE:   settle_ticks = val;
            REG_MIN_PWM:    duty_floor = val[7:0];
            REG_MAX_PWM:    duty_ceil = val[7:0];
            REG_START_MODE: in_close = (val[1:0] == MODE_CLOSE);
            default:        ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain_block();
        in_valid = 1'b0;
        while (awaited_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    // offers one word and records what it should produce once taken
    task automatic offer_word(input in_word_t w, input out_word_t typed_res, input bit typed);
        out_word_t guess;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        guess = next_haptic_word(w);
        awaited_outputs.push_back(typed ? typed_res : guess);
        @(negedge clk);
    endtask

    // receiver side, with a long hold-off on request
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else if ($urandom_range(99) < rx_stall_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_outputs.size() == 0)
            begin
                $error("result word arrived with none awaited");
                mismatch_count++;
            end
            else
            begin
                want_word = awaited_outputs.pop_front();
                if (out_data.motor_pwm !== want_word.motor_pwm)
                begin
                    $error("motor_pwm: expected %0d, got %0d",
                           want_word.motor_pwm, out_data.motor_pwm);
                    mismatch_count++;
                end
                if (out_data.current_mode !== want_word.current_mode)
                begin
                    $error("current_mode: expected %0d, got %0d",
                           want_word.current_mode, out_data.current_mode);
                    mismatch_count++;
                end
                if (out_data.mode_changed !== want_word.mode_changed)
                begin
                    $error("mode_changed: expected %0d, got %0d",
                           want_word.mode_changed, out_data.mode_changed);
                    mismatch_count++;
                end
                if (out_data.smoothed_distance !== want_word.smoothed_distance)
                begin
                    $error("smoothed_distance: expected %0d, got %0d",
                           want_word.smoothed_distance, out_data.smoothed_distance);
                    mismatch_count++;
                end
                if (out_data.distance_valid !== want_word.distance_valid)
                begin
                    $error("distance_valid: expected %0d, got %0d",
                           want_word.distance_valid, out_data.distance_valid);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] reg_vals [REG_COUNT];
        int                    mask;
        flex_limit = FLEX_THR_RST;
        nav_cm = NAV_THR_RST;
        close_cm = CLOSE_THR_RST;
        weight = ALPHA_RST;
        settle_ticks = DEBOUNCE_RST;
        duty_floor = MIN_PWM_RST;
        duty_ceil = MAX_PWM_RST;
        in_close = (START_MODE_RST == MODE_CLOSE);
        prev_level = 1'b1;
        held_level = 1'b1;
        steady_run = '0;
        avg_q8 = '0;
        avg_ok = 1'b0;
        duty_held = '0;

        // idle tick, flex at threshold, out of range, under one cm
        add_checked_tick(tick_of(1, 0, 0, 0, 0), result_of(0, MODE_NAV, 0, 0, 0));
        add_checked_tick(tick_of(1, 1, 500, 300, 0), result_of(0, MODE_NAV, 0, 0, 0));
        add_checked_tick(tick_of(1, 1, 4095, 8191, 1), result_of(0, MODE_NAV, 0, 0, 0));
        add_checked_tick(tick_of(1, 1, 501, 9, 0), result_of(0, MODE_NAV, 0, 0, 0));
        // filter load, then smoothing toward far and near readings
        add_tick(tick_of(1, 1, 501, 500, 0));
        add_tick(tick_of(1, 1, 4095, 8191, 0));
        add_tick(tick_of(1, 1, 4095, 150, 0));
        // press too short for the debounce, duty held without a sample
        add_tick(tick_of(0, 0, 0, 0, 0));
        add_tick(tick_of(1, 0, 4095, 8191, 1));
        add_checked_tick(tick_of(1, 1, 500, 300, 0), result_of(0, MODE_NAV, 0, 0, 0));
        // zero debounce: a press toggles on the tick it appears
        add_write(REG_DEBOUNCE, 0);
        add_checked_tick(tick_of(0, 0, 0, 0, 0), result_of(0, MODE_CLOSE, 1, 0, 0));
        add_tick(tick_of(0, 1, 2000, 30, 0));
        add_tick(tick_of(1, 0, 0, 0, 0));
        add_tick(tick_of(0, 0, 0, 0, 0));
        // raw weight, inverted ramp, weight above one
        add_write(REG_ALPHA, ALPHA_ONE);
        add_write(REG_MIN_PWM, 255);
        add_write(REG_MAX_PWM, 0);
        add_tick(tick_of(1, 1, 4095, 200, 0));
        add_tick(tick_of(1, 1, 4095, 100, 0));
        add_write(REG_ALPHA, 511);
        add_tick(tick_of(1, 1, 4095, 8191, 0));
        // zero threshold gives no duty; then start mode codes and flex thresholds at both ends
        add_write(REG_MAX_PWM, 255);
        add_write(REG_NAV_THR, 0);
        add_tick(tick_of(1, 1, 4095, 50, 0));
        add_write(REG_START_MODE, MODE_CLOSE);
        add_tick(tick_of(1, 1, 4095, 10, 0));
        add_write(REG_START_MODE, MODE_BOTH);
        add_tick(tick_of(1, 1, 4095, 10, 0));
        add_write(REG_START_MODE, MODE_NONE);
        add_write(REG_FLEX_THR, 0);
        add_tick(tick_of(1, 1, 0, 100, 0));
        add_tick(tick_of(1, 1, 1, 100, 0));
        add_write(REG_FLEX_THR, 4095);
        add_tick(tick_of(1, 1, 4095, 100, 0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                drain_block();
                write_reg(script[i].reg_index, script[i].reg_value);
            end
            else
                offer_word(script[i].word, script[i].typed_result, script[i].typed);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_block();
            case (ph)
                0: reg_vals = '{500, 80, 4, 90, 5, 100, 255, MODE_NAV};
                1: reg_vals = '{0, 1, 1, 0, 0, 0, 0, MODE_CLOSE};
                2: reg_vals = '{4094, 1023, 1023, 511, 65535, 255, 255, MODE_BOTH};
                3: reg_vals = '{1000, 0, 1023, 256, 1, 255, 0, MODE_NONE};
                default:
                begin
                    for (int r = 0; r < REG_COUNT; r++)
                    begin
                        mask = (1 << REG_BITS[r]) - 1;
                        if ($urandom_range(99) < 20)
                            reg_vals[r] = CFG_DATA_W'($urandom_range(1) ? mask : 0);
                        else if (r == REG_DEBOUNCE)
                            reg_vals[r] = CFG_DATA_W'($urandom_range(0, 12));
                        else
                            reg_vals[r] = CFG_DATA_W'($urandom & mask);
                    end
                end
            endcase
            for (int r = 0; r < REG_COUNT; r++)
                write_reg(CFG_INDEX_W'(r), reg_vals[r]);
            case (ph % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 55;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 55;
                end
                default:
                begin
                    tx_idle_pct = 15;
                    rx_stall_pct = 15;
                end
            endcase
            // receiver holds off while words keep coming, so the block backs up
            if (ph == PRESSURE_PHASE)
                hold_off_req = 1'b1;
            repeat (WORDS_PER_PHASE) offer_word(random_tick(), '0, 1'b0);
        end

        in_valid = 1'b0;
        while (awaited_outputs.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
        if (mismatch_count == 0)
            $display("proximity_haptic_driver_tb OK");
        else
            $display("proximity_haptic_driver_tb NOT OK");
        $finish;
    end

endmodule
